>>> rtl/lev_pkg.sv
// ----------------------------------------------------------------------------
// lev_pkg - shared types and constants for the edit distance core
// Sequencer states, operation codes, the saturation limit, the threshold
// reset value and the saturating increment used by the row update.
// ----------------------------------------------------------------------------
package lev_pkg;

  // Operation codes carried on the op field of an input request.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Largest distance that can be reported; every sum clamps here.
  localparam logic [7:0] DIST_MAX = 8'd255;

  // Value of the near-match threshold after reset.
  localparam logic [7:0] THRESHOLD_RESET = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } lev_state_e;

  // Adds a single bit to a distance, clamping at the saturation limit.
  function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic add);
    logic [8:0] sum;
    sum = {1'b0, v} + {8'd0, add};
    if (sum > {1'b0, DIST_MAX}) begin
      sat_inc = DIST_MAX;
    end else begin
      sat_inc = sum[7:0];
    end
  endfunction

endpackage

>>> rtl/levenshtein_distance_core.sv
// ----------------------------------------------------------------------------
// levenshtein_distance_core - streaming Levenshtein edit distance engine
// Holds a reference string and one row of the edit distance table, and
// updates that row one cell per cycle for every query symbol.
// ----------------------------------------------------------------------------
// Usage. Input requests (op_i, symbol_i, last_i) are taken when in_valid_i is
// high and in_stall_o is low. A load request (op 0) appends one symbol to the
// reference, or flags it too long once it holds MAX_LEN symbols; the first
// load after a closed reference starts a new one, and last_i closes it. A
// query request (op 1) feeds one symbol of the query string. The block then
// stalls its input while it walks the stored row with its single cell update
// unit, which reads one row entry and one reference symbol per cycle from its
// two memories. After the last query symbol one result request (distance_o,
// close_o, too_long_o) is raised on out_valid_o; it stays put while
// out_stall_i is high, and the block keeps accepting input meanwhile, only
// pausing at the end of a further query if the result is still waiting.
// The threshold register is written through the cfg channel, which is always
// ready. Reset empties the reference, restores the row to its initial
// counts at once through per-entry valid bits, and sets the threshold to 3.
// ----------------------------------------------------------------------------
module levenshtein_distance_core #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [20:0] symbol_i,
  input  logic        last_i,
  // Result request channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  distance_o,
  output logic        close_o,
  output logic        too_long_o,
  // Threshold register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_close_threshold_i
);

  // Length counters must hold MAX_LEN itself; addresses only MAX_LEN - 1.
  localparam int LenW  = $clog2(MAX_LEN + 1);
  localparam int AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Reference symbols. Only entries below the reference length are read.
  logic [20:0] ref_mem [MAX_LEN];
  // Row entries 1..MAX_LEN live at addresses 0..MAX_LEN-1. An entry whose
  // valid bit is clear reads as its initial value, namely its column index.
  logic [7:0]  row_mem [MAX_LEN];
  logic [MAX_LEN-1:0] row_vld_q;

  lev_pkg::lev_state_e state_q, state_d;

  logic [LenW-1:0]  ref_len_q, ref_len_d;
  logic             load_open_q, load_open_d;
  logic             ref_trunc_q, ref_trunc_d;
  logic [LenW-1:0]  qry_cnt_q, qry_cnt_d;
  logic             qry_trunc_q, qry_trunc_d;
  logic [7:0]       row0_q, row0_d;
  logic [7:0]       thresh_q;

  // Working registers of the cell update unit.
  logic [20:0]      sym_q, sym_d;
  logic             last_q, last_d;
  logic [7:0]       left_q, left_d;
  logic [7:0]       diag_q, diag_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  // Registered memory read data and the valid bit sampled with it.
  logic [20:0]      ref_rdata_q;
  logic [7:0]       row_rdata_q;
  logic             row_rvld_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_dist_q, out_dist_d;
  logic             out_close_q, out_close_d;
  logic             out_long_q, out_long_d;

  // Memory and row control.
  logic             ref_we;
  logic [AddrW-1:0] ref_waddr;
  logic             row_we;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             row_clear;

  // Cell update datapath.
  logic [7:0]       above;
  logic [7:0]       cand_up;
  logic [7:0]       cand_left;
  logic [7:0]       cand_diag;
  logic [7:0]       cell_min;
  logic [LenW-1:0]  load_idx;
  logic [LenW-1:0]  next_cell;

  assign in_stall_o  = (state_q != lev_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign close_o     = out_close_q;
  assign too_long_o  = out_long_q;

  // The entry above the current cell: stored value, or its column index
  // (address plus one) if it has not been written since the row was reset.
  assign above     = row_rvld_q ? row_rdata_q : (8'(cnt_q) + 8'd1);
  assign cand_up   = lev_pkg::sat_inc(above, 1'b1);
  assign cand_left = lev_pkg::sat_inc(left_q, 1'b1);
  assign cand_diag = lev_pkg::sat_inc(diag_q, (ref_rdata_q != sym_q));

  always_comb begin
    cell_min = cand_up;
    if (cand_left < cell_min) begin
      cell_min = cand_left;
    end
    if (cand_diag < cell_min) begin
      cell_min = cand_diag;
    end
  end

  assign load_idx  = load_open_q ? ref_len_q : '0;
  assign next_cell = LenW'(cnt_q) + LenW'(1);

  // Sequencer: next state and control.
  always_comb begin
    state_d     = state_q;
    ref_len_d   = ref_len_q;
    load_open_d = load_open_q;
    ref_trunc_d = ref_trunc_q;
    qry_cnt_d   = qry_cnt_q;
    qry_trunc_d = qry_trunc_q;
    row0_d      = row0_q;
    sym_d       = sym_q;
    last_d      = last_q;
    left_d      = left_q;
    diag_d      = diag_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_dist_d  = out_dist_q;
    out_close_d = out_close_q;
    out_long_d  = out_long_q;
    ref_we      = 1'b0;
    ref_waddr   = load_idx[AddrW-1:0];
    row_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    row_clear   = 1'b0;

    case (state_q)
      lev_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == lev_pkg::OP_LOAD) begin
            // A load into a closed reference starts a fresh one.
            if (load_idx < LenW'(MAX_LEN)) begin
              ref_we      = 1'b1;
              ref_len_d   = load_idx + LenW'(1);
              ref_trunc_d = load_open_q & ref_trunc_q;
            end else begin
              ref_len_d   = load_idx;
              ref_trunc_d = 1'b1;
            end
            load_open_d = !last_i;
            row_clear   = 1'b1;
          end else begin
            sym_d  = symbol_i;
            last_d = last_i;
            diag_d = row0_q;
            left_d = lev_pkg::sat_inc(row0_q, 1'b1);
            row0_d = lev_pkg::sat_inc(row0_q, 1'b1);
            if (qry_cnt_q < LenW'(MAX_LEN)) begin
              qry_cnt_d = qry_cnt_q + LenW'(1);
            end else begin
              qry_trunc_d = 1'b1;
            end
            if (ref_len_q == '0) begin
              state_d = lev_pkg::ST_FINISH;
            end else begin
              rd_en   = 1'b1;
              cnt_d   = '0;
              state_d = lev_pkg::ST_RUN;
            end
          end
        end
      end

      lev_pkg::ST_RUN: begin
        // One cell per cycle; the next read overlaps the current write.
        row_we = 1'b1;
        left_d = cell_min;
        diag_d = above;
        if (next_cell < ref_len_q) begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(cnt_q + AddrW'(1));
          cnt_d   = AddrW'(cnt_q + AddrW'(1));
        end else begin
          state_d = lev_pkg::ST_FINISH;
        end
      end

      lev_pkg::ST_FINISH: begin
        if (!last_q) begin
          state_d = lev_pkg::ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_dist_d  = left_q;
          out_close_d = (left_q < thresh_q);
          out_long_d  = ref_trunc_q | qry_trunc_q;
          row_clear   = 1'b1;
          state_d     = lev_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lev_pkg::ST_IDLE;
      end
    endcase

    if (row_clear) begin
      row0_d      = '0;
      qry_cnt_d   = '0;
      qry_trunc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lev_pkg::ST_IDLE;
      ref_len_q   <= '0;
      load_open_q <= 1'b0;
      ref_trunc_q <= 1'b0;
      qry_cnt_q   <= '0;
      qry_trunc_q <= 1'b0;
      row0_q      <= '0;
      row_vld_q   <= '0;
      thresh_q    <= lev_pkg::THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ref_len_q   <= ref_len_d;
      load_open_q <= load_open_d;
      ref_trunc_q <= ref_trunc_d;
      qry_cnt_q   <= qry_cnt_d;
      qry_trunc_q <= qry_trunc_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
      if (row_clear) begin
        row_vld_q <= '0;
      end else if (row_we) begin
        row_vld_q[cnt_q] <= 1'b1;
      end
      if (cfg_valid_i) begin
        thresh_q <= cfg_close_threshold_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    last_q      <= last_d;
    left_q      <= left_d;
    diag_q      <= diag_d;
    cnt_q       <= cnt_d;
    out_dist_q  <= out_dist_d;
    out_close_q <= out_close_d;
    out_long_q  <= out_long_d;
  end

  // Reference memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= symbol_i;
    end
    if (rd_en) begin
      ref_rdata_q <= ref_mem[rd_addr];
    end
  end

  // Row memory: written at the current cell, read one cell ahead.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[cnt_q] <= cell_min;
    end
    if (rd_en) begin
      row_rdata_q <= row_mem[rd_addr];
      row_rvld_q  <= row_vld_q[rd_addr];
    end
  end

endmodule
